// File: sv/rpb_pkg.sv
// ----------------------------------------------------------------------------
// rpb_pkg
// Ready priority bitmap definitions: status codes, item kinds, PRIO_W.
// ----------------------------------------------------------------------------
package rpb_pkg;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_RANGE     = 2'd3
	} status_t;

	// item kinds
	localparam logic KIND_MAKE   = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	// width of a priority number on the ports
	localparam int unsigned PRIO_W = 8;

endpackage

// File: sv/ready_priority_bitmap.sv
// ----------------------------------------------------------------------------
// ready_priority_bitmap
// Ready-set tracker for a priority scheduler: per-priority ready counts, a
// bitmap of ready priorities in groups, and a two-level highest-ready search.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat (kind, priority_req) is taken on a clock edge with start
//   high and busy low. busy stays low: one command is taken every cycle.
//   kind make adds one ready entry at that priority, kind remove takes one.
//   Each command gives one result beat: done rises after the command has passed
//   stage 1 and stage 2 and is high for exactly one cycle with highest_ready,
//   any_ready and status, which reflect the state after that command. The
//   receiver cannot stall.
//   Throughput is one command per cycle. The counts live in a
//   single-port-write memory with a registered read issued at accept; the
//   write-back of one command is forwarded to the next command at the same
//   priority.
//   top_priority is written on the cfg channel (cfg_ready is always high).
//   Write it only while no command is in flight; the block does not check.
//   Reset clears the ready bitmap, so all counts read as zero at once (an
//   entry whose ready bit is clear is taken as count zero, no clearing
//   pass), and sets top_priority to 255.
// ----------------------------------------------------------------------------
module ready_priority_bitmap #(
	parameter int unsigned NUM_PRIOS   = 256,
	parameter int unsigned GROUP_SIZE  = 16,
	parameter int unsigned COUNT_WIDTH = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      kind,
	input  logic [rpb_pkg::PRIO_W-1:0] priority_req,
	output logic                      done,
	output logic [rpb_pkg::PRIO_W-1:0] highest_ready,
	output logic                      any_ready,
	output logic [1:0]                status,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [rpb_pkg::PRIO_W-1:0] cfg_data
);
	import rpb_pkg::*;

	localparam int unsigned NUM_GROUPS = (NUM_PRIOS + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int unsigned PAD_W      = NUM_GROUPS * GROUP_SIZE;
	localparam int unsigned IDX_W      = $clog2(NUM_PRIOS);
	localparam int unsigned GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
	localparam int unsigned BIT_W      = $clog2(GROUP_SIZE);
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
	localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);
	localparam logic [PRIO_W:0]        PRIO_LIMIT = (PRIO_W+1)'(NUM_PRIOS);

	logic accept;

	// configuration
	logic [PRIO_W-1:0] top_priority_q;

	// stage 1: command under update
	logic                   valid_s1;
	logic                   kind_s1;
	logic [IDX_W-1:0]       prio_s1;
	logic                   range_err_s1;
	logic [COUNT_WIDTH-1:0] rd_cnt_s1;
	logic                   byp_s1;
	logic [COUNT_WIDTH-1:0] byp_cnt_s1;

	// state
	logic [NUM_PRIOS-1:0]   ready_bits_q;
	logic [NUM_GROUPS-1:0]  group_bits_q;
	logic [COUNT_WIDTH-1:0] count_mem [NUM_PRIOS];

	// stage 2: search
	logic    valid_s2;
	status_t status_s2;

	// result register
	logic              done_q;
	logic [PRIO_W-1:0] highest_q;
	logic              any_q;
	status_t           status_q;

	// stage 1 combinational
	logic                   ready_bit;
	logic [COUNT_WIDTH-1:0] cnt_cur;
	logic [COUNT_WIDTH-1:0] cnt_new;
	status_t                status_new;
	logic                   wr_en;
	logic                   bit_set;
	logic                   bit_clr;
	logic [NUM_PRIOS-1:0]   ready_next;
	logic [PAD_W-1:0]       padded_next;
	logic [NUM_GROUPS-1:0]  group_next;

	// stage 2 combinational
	logic [PAD_W-1:0]      padded_cur;
	logic [GRP_W-1:0]      grp_sel;
	logic [GROUP_SIZE-1:0] grp_word;
	logic [BIT_W-1:0]      bit_sel;
	logic [15:0]           hp_full;

	assign accept    = start && !busy;
	// every command finishes in fixed time, so the block never holds off
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_priority_q <= 8'd255;
		end else if (cfg_valid && cfg_ready) begin
			top_priority_q <= cfg_data;
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// stage 1 payload, with forwarding of the write made at this same edge
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1      <= kind;
			prio_s1      <= priority_req[IDX_W-1:0];
			range_err_s1 <= (priority_req > top_priority_q) ||
				({1'b0, priority_req} >= PRIO_LIMIT);
			byp_s1       <= wr_en && (prio_s1 == priority_req[IDX_W-1:0]);
			byp_cnt_s1   <= cnt_new;
		end
	end

	// count memory: read at accept, write back from stage 1
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_cnt_s1 <= count_mem[priority_req[IDX_W-1:0]];
		end
		if (wr_en) begin
			count_mem[prio_s1] <= cnt_new;
		end
	end

	// current count: a clear ready bit means count zero
	always_comb begin
		ready_bit = ready_bits_q[prio_s1];
		if (!ready_bit) begin
			cnt_cur = '0;
		end else if (byp_s1) begin
			cnt_cur = byp_cnt_s1;
		end else begin
			cnt_cur = rd_cnt_s1;
		end
	end

	// update decision
	always_comb begin
		status_new = ST_OK;
		if (range_err_s1) begin
			status_new = ST_RANGE;
		end else if (kind_s1 == KIND_MAKE) begin
			if (cnt_cur == COUNT_MAX) begin
				status_new = ST_OVERFLOW;
			end
		end else begin
			if (!ready_bit) begin
				status_new = ST_UNDERFLOW;
			end
		end
		cnt_new = (kind_s1 == KIND_MAKE) ? (cnt_cur + COUNT_ONE) : (cnt_cur - COUNT_ONE);
		wr_en   = valid_s1 && (status_new == ST_OK);
		bit_set = wr_en && (kind_s1 == KIND_MAKE);
		bit_clr = wr_en && (kind_s1 == KIND_REMOVE) && (cnt_cur == COUNT_ONE);
	end

	// next bitmap and group bits
	always_comb begin
		ready_next = ready_bits_q;
		if (bit_set) begin
			ready_next[prio_s1] = 1'b1;
		end
		if (bit_clr) begin
			ready_next[prio_s1] = 1'b0;
		end
		padded_next = PAD_W'(ready_next);
		for (int g = 0; g < NUM_GROUPS; g++) begin
			group_next[g] = |padded_next[g*GROUP_SIZE +: GROUP_SIZE];
		end
	end

	// state and stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_bits_q <= '0;
			group_bits_q <= '0;
			valid_s2     <= 1'b0;
		end else begin
			ready_bits_q <= ready_next;
			group_bits_q <= group_next;
			valid_s2     <= valid_s1;
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			status_s2 <= status_new;
		end
	end

	// two-level search: highest group, then highest bit in its word
	always_comb begin
		padded_cur = PAD_W'(ready_bits_q);
		grp_sel = '0;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			if (group_bits_q[g]) begin
				grp_sel = GRP_W'(g);
			end
		end
		grp_word = padded_cur[grp_sel*GROUP_SIZE +: GROUP_SIZE];
		bit_sel = '0;
		for (int b = 0; b < GROUP_SIZE; b++) begin
			if (grp_word[b]) begin
				bit_sel = BIT_W'(b);
			end
		end
		hp_full = 16'(grp_sel) * 16'(GROUP_SIZE) + 16'(bit_sel);
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s2;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (valid_s2) begin
			any_q     <= |group_bits_q;
			highest_q <= (|group_bits_q) ? hp_full[PRIO_W-1:0] : '0;
			status_q  <= status_s2;
		end
	end

	assign done          = done_q;
	assign highest_ready = highest_q;
	assign any_ready     = any_q;
	assign status        = status_q;

`ifndef SYNTHESIS
	// every result beat comes from a command taken earlier
	a_done_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 3))
		else $error("result beat without a matching command");

	// nothing ready reports priority zero
	a_idle_reports_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !any_ready |-> highest_ready == '0)
		else $error("highest_ready not zero with nothing ready");

	// group bits agree with the bitmap being empty or not
	a_group_matches_bitmap: assert property (@(posedge clk) disable iff (!arst_n)
		(ready_bits_q == '0) == (group_bits_q == '0))
		else $error("group bits disagree with ready bitmap");

	// a rejected command leaves the bitmap alone
	a_reject_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (status_new != ST_OK) |=> ready_bits_q == $past(ready_bits_q))
		else $error("rejected command changed the ready bitmap");
`endif

endmodule
